// ===== hdl/capture_period_frequency_meter_assert.svh =====
// Assertion macros used by the checker file of the frequency meter.
// Each macro writes one labeled concurrent assertion on clk with an $error report.
`ifndef CAPTURE_PERIOD_FREQUENCY_METER_ASSERT_SVH
`define CAPTURE_PERIOD_FREQUENCY_METER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define CPFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define CPFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CPFM_ASSERT_RESET(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cpfm_pkg.sv =====
// Widths, types and constants of the capture period frequency meter.
// Used by the top level and by its checker; depends on nothing.
package cpfm_pkg;

  localparam int ChanW = 2;
  localparam int CaptureW = 16;
  localparam int PeriodW = 17;
  localparam int FreqW = 27;
  localparam int CounterBits = 16;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [CaptureW-1:0] capture_t;
  typedef logic [PeriodW-1:0] period_t;
  typedef logic [FreqW-1:0] freq_t;
  typedef logic [CounterBits-1:0] count_t;

  localparam freq_t TickRateReset = 27'd1000000;
  localparam period_t PeriodMax = period_t'(1) << CounterBits;

endpackage

// ===== hdl/capture_period_frequency_meter.sv =====
// Channel   | Signals                                  | Direction
// cfg       | cfg_valid, cfg_ready, cfg_data           | in  (tick_rate_hz)
// capture   | in_valid, in_ready, channel, capture_value | in
// result    | out_valid, out_ready, out_channel, period_ticks, frequency_hz | out
//
// A first capture of a channel only stores its value. A second capture forms the
// period, runs 27 steps of a shared restoring divider, then delivers the result.
// Reset clears the pairing state and result valid flag and presets the tick rate.
// A result that waits on out_ready holds the divider, and in_ready is low meanwhile.
// Depends on cpfm_pkg; NUM_CHANNELS may range from 1 to 4.
module capture_period_frequency_meter #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cpfm_pkg::FreqW-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cpfm_pkg::ChanW-1:0]  channel,
  input  logic [cpfm_pkg::CaptureW-1:0] capture_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cpfm_pkg::ChanW-1:0]  out_channel,
  output logic [cpfm_pkg::PeriodW-1:0] period_ticks,
  output logic [cpfm_pkg::FreqW-1:0]  frequency_hz
);

  localparam int IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int StepW = $clog2(cpfm_pkg::FreqW);
  localparam logic [StepW-1:0] LastStep = StepW'(cpfm_pkg::FreqW - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVIDE = 2'd1;
  localparam logic [1:0] ST_DELIVER = 2'd2;

  logic [1:0] state;
  logic [StepW-1:0] step;
  cpfm_pkg::freq_t tick_rate;
  logic [NUM_CHANNELS-1:0] awaiting_second;
  cpfm_pkg::count_t first_capture [NUM_CHANNELS];
  cpfm_pkg::freq_t quo;
  logic [cpfm_pkg::PeriodW-1:0] rem;
  cpfm_pkg::period_t divisor;
  cpfm_pkg::chan_t chan_hold;

  logic accept;
  logic in_range;
  logic [IdxW-1:0] idx;
  cpfm_pkg::count_t cap_low;
  cpfm_pkg::count_t diff;
  logic [cpfm_pkg::PeriodW:0] rem_shift;
  logic [cpfm_pkg::PeriodW:0] rem_sub;
  logic fits;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;
  assign in_range = ({3'b000, channel} < 5'(NUM_CHANNELS));
  assign idx = IdxW'(channel);
  assign cap_low = cpfm_pkg::CounterBits'(capture_value);
  assign diff = cap_low - first_capture[idx];

  assign rem_shift = {rem, quo[cpfm_pkg::FreqW-1]};
  assign rem_sub = rem_shift - {1'b0, divisor};
  assign fits = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate <= cpfm_pkg::TickRateReset;
    end else if (cfg_valid) begin
      tick_rate <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      awaiting_second <= '0;
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      if (state == ST_DELIVER && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_range) begin
            awaiting_second[idx] <= !awaiting_second[idx];
            if (awaiting_second[idx]) begin
              state <= ST_DIVIDE;
              step <= '0;
            end
          end
        end
        ST_DIVIDE: begin
          if (step == LastStep) begin
            state <= ST_DELIVER;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DELIVER: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && in_range) begin
      if (!awaiting_second[idx]) begin
        first_capture[idx] <= cap_low;
      end else begin
        divisor <= {(diff == '0), diff};
        quo <= tick_rate;
        rem <= '0;
        chan_hold <= channel;
      end
    end else if (state == ST_DIVIDE) begin
      rem <= fits ? rem_sub[cpfm_pkg::PeriodW-1:0] : rem_shift[cpfm_pkg::PeriodW-1:0];
      quo <= {quo[cpfm_pkg::FreqW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DELIVER && (!out_valid || out_ready)) begin
      out_channel <= chan_hold;
      period_ticks <= divisor;
      frequency_hz <= quo;
    end
  end

endmodule

// ===== hdl/cpfm_checker.sv =====
// Port-level checker of the capture period frequency meter, bound to the top level.
// Depends on cpfm_pkg and on capture_period_frequency_meter_assert.svh.
`include "capture_period_frequency_meter_assert.svh"

module cpfm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cpfm_pkg::ChanW-1:0]    out_channel,
  input logic [cpfm_pkg::PeriodW-1:0]  period_ticks,
  input logic [cpfm_pkg::FreqW-1:0]    frequency_hz
);

  logic period_ok;
  logic take_idle;
  logic [cpfm_pkg::ChanW+cpfm_pkg::PeriodW+cpfm_pkg::FreqW-1:0] result_word;

  assign period_ok = (period_ticks != '0) && (period_ticks <= cpfm_pkg::PeriodMax);
  assign take_idle = out_valid && out_ready && in_ready;
  assign result_word = {out_channel, period_ticks, frequency_hz};

  `CPFM_ASSERT_RESET(a_reset_clears, rst, !out_valid, "result word valid after reset")
  `CPFM_ASSERT_NOW(a_period_range, out_valid, period_ok, "period out of range")
  `CPFM_ASSERT_NOW(a_rise_while_busy, $rose(out_valid), $past(!in_ready), "result while idle")
  `CPFM_ASSERT_NEXT(a_gap_after_take, take_idle, !out_valid, "result without a division")
  `CPFM_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(result_word), "stalled word changed")

endmodule

bind capture_period_frequency_meter cpfm_checker u_cpfm_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_channel(out_channel),
  .period_ticks(period_ticks),
  .frequency_hz(frequency_hz)
);
